// ===== src/utf8ws_pkg.sv =====
package utf8ws_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int SLOTS = 3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] LEAD_C2  = 8'hc2;
  localparam logic [7:0] LEAD_E1  = 8'he1;
  localparam logic [7:0] LEAD_E2  = 8'he2;
  localparam logic [7:0] LEAD_E3  = 8'he3;
  localparam logic [7:0] CONT_80  = 8'h80;
  localparam logic [7:0] CONT_81  = 8'h81;
  localparam logic [7:0] CONT_85  = 8'h85;
  localparam logic [7:0] CONT_8A  = 8'h8a;
  localparam logic [7:0] CONT_9A  = 8'h9a;
  localparam logic [7:0] CONT_9F  = 8'h9f;
  localparam logic [7:0] CONT_A0  = 8'ha0;
  localparam logic [7:0] CONT_A8  = 8'ha8;
  localparam logic [7:0] CONT_A9  = 8'ha9;
  localparam logic [7:0] CONT_AF  = 8'haf;

  typedef enum logic [1:0] {
    ROLE_SPACE = 2'd0,
    ROLE_OPEN  = 2'd1,
    ROLE_CLOSE = 2'd2,
    ROLE_WORD  = 2'd3
  } role_t;

  // fail: not whitespace; len zero without fail: prefix still open
  typedef struct packed {
    logic       fail;
    logic [1:0] len;
  } match_t;

  typedef struct packed {
    logic [SLOTS-1:0][7:0] bytes;
    role_t [SLOTS-1:0]     roles;
    logic [SLOTS-1:0]      wstart;
    logic [1:0]            count;
    logic                  last;
  } group_t;

  function automatic match_t ws_match(input logic [7:0] c0, input logic [7:0] c1,
                                      input logic [7:0] c2, input logic [1:0] avail);
    match_t m;
    m.fail = 1'b0;
    m.len  = 2'd0;
    if (c0 == CH_SPACE || (c0 >= CH_TAB && c0 <= CH_CR)) begin
      m.len = 2'd1;
    end else if (c0 == LEAD_C2) begin
      if (avail >= 2'd2) begin
        if (c1 inside {CONT_85, CONT_A0}) m.len = 2'd2;
        else m.fail = 1'b1;
      end
    end else if (c0 == LEAD_E1) begin
      if (avail >= 2'd2) begin
        if (c1 != CONT_9A) m.fail = 1'b1;
        else if (avail == 2'd3) begin
          if (c2 == CONT_80) m.len = 2'd3;
          else m.fail = 1'b1;
        end
      end
    end else if (c0 == LEAD_E2) begin
      if (avail >= 2'd2) begin
        if (c1 == CONT_80) begin
          if (avail == 2'd3) begin
            if (c2 inside {[CONT_80:CONT_8A], CONT_A8, CONT_A9, CONT_AF}) m.len = 2'd3;
            else m.fail = 1'b1;
          end
        end else if (c1 == CONT_81) begin
          if (avail == 2'd3) begin
            if (c2 == CONT_9F) m.len = 2'd3;
            else m.fail = 1'b1;
          end
        end else begin
          m.fail = 1'b1;
        end
      end
    end else if (c0 == LEAD_E3) begin
      if (avail >= 2'd2) begin
        if (c1 != CONT_80) m.fail = 1'b1;
        else if (avail == 2'd3) begin
          if (c2 == CONT_80) m.len = 2'd3;
          else m.fail = 1'b1;
        end
      end
    end else begin
      m.fail = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== src/utf8_whitespace_tokenizer.sv =====
// byte-serial tokenizer front end: labels each source byte as whitespace,
// open paren, close paren or word byte, and flags the first byte of each word
// input channel: in_valid / in_stall with in_src_byte and in_end_of_source;
// a zero byte or the end flag closes the source and flushes held bytes
// output channel: out_valid / out_stall with out_byte, out_role,
// out_word_start and out_final_result, one labelled byte per request
// throughput: one input byte per cycle while in_stall is low; the output port gives
// one result per cycle while out_stall is low, so the results of a byte that
// releases a held utf-8 prefix (up to three results) leave it one after another
// out_valid rises once a result has passed the queue into the output register
// an input byte that only extends a utf-8 prefix produces no result yet
// a four-entry queue sits between the classifier and the output register;
// in_stall rises only when that queue is full
// out_stall freezes the output register; the queue keeps filling meanwhile
// reset (synchronous, active low) empties the queue and output register and
// clears the held prefix and word tracking
module utf8_whitespace_tokenizer #(
  parameter int QUEUE_DEPTH = utf8ws_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_src_byte,
  input  logic       in_end_of_source,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_role,
  output logic       out_word_start,
  output logic       out_final_result
);

  utf8ws_pkg::group_t push_data;
  utf8ws_pkg::group_t head;
  logic               push;
  logic               pop;
  logic               empty;
  logic               full;

  utf8ws_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_src_byte      (in_src_byte),
    .in_end_of_source (in_end_of_source),
    .in_stall         (in_stall),
    .q_full           (full),
    .q_push           (push),
    .q_data           (push_data)
  );

  utf8ws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  utf8ws_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_role         (out_role),
    .out_word_start   (out_word_start),
    .out_final_result (out_final_result)
  );

endmodule

// ===== src/utf8ws_front.sv =====
module utf8ws_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_src_byte,
  input  logic                in_end_of_source,
  output logic                in_stall,
  input  logic                q_full,
  output logic                q_push,
  output utf8ws_pkg::group_t  q_data
);

  logic [1:0][7:0] held_r, held_nxt;
  logic [1:0]      held_cnt_r, held_cnt_nxt;
  logic            in_word_r, in_word_nxt;

  logic [2:0][7:0] win;
  logic [2:0]      n;
  logic [2:0]      pos;
  logic            ending;
  logic            stop;
  logic            iw;
  logic            accept;
  utf8ws_pkg::match_t mt;
  utf8ws_pkg::group_t grp;

  function automatic logic [7:0] pick(input logic [2:0][7:0] w, input logic [2:0] idx);
    return (idx < 3'd3) ? w[idx[1:0]] : utf8ws_pkg::CH_NUL;
  endfunction

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;

  always_comb begin
    win = '0;
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < held_cnt_r) win[i] = held_r[i];
    end
    n = {1'b0, held_cnt_r};
    if (in_src_byte != utf8ws_pkg::CH_NUL) begin
      win[held_cnt_r] = in_src_byte;
      n = n + 3'd1;
    end
    ending = in_end_of_source || (in_src_byte == utf8ws_pkg::CH_NUL);

    grp.bytes  = win;
    grp.roles  = {utf8ws_pkg::SLOTS{utf8ws_pkg::ROLE_SPACE}};
    grp.wstart = '0;
    grp.last   = ending;
    pos        = 3'd0;
    stop       = 1'b0;
    iw         = in_word_r;
    held_nxt   = '0;
    held_cnt_nxt = 2'd0;
    mt         = '0;

    for (int it = 0; it < utf8ws_pkg::SLOTS; it++) begin
      if (!stop && pos < n) begin
        mt = utf8ws_pkg::ws_match(pick(win, pos), pick(win, pos + 3'd1),
                                  pick(win, pos + 3'd2), 2'(n - pos));
        if (!mt.fail && mt.len != 2'd0) begin
          for (int j = 0; j < utf8ws_pkg::SLOTS; j++) begin
            if (3'(j) >= pos && 3'(j) < pos + {1'b0, mt.len}) begin
              grp.roles[j]  = utf8ws_pkg::ROLE_SPACE;
              grp.wstart[j] = 1'b0;
            end
          end
          pos = pos + {1'b0, mt.len};
          iw  = 1'b0;
        end else if (!mt.fail && !ending) begin
          held_nxt[0]  = pick(win, pos);
          held_nxt[1]  = pick(win, pos + 3'd1);
          held_cnt_nxt = 2'(n - pos);
          stop = 1'b1;
        end else begin
          if (win[pos[1:0]] == utf8ws_pkg::CH_OPEN) begin
            grp.roles[pos[1:0]] = utf8ws_pkg::ROLE_OPEN;
            iw = 1'b0;
          end else if (win[pos[1:0]] == utf8ws_pkg::CH_CLOSE) begin
            grp.roles[pos[1:0]] = utf8ws_pkg::ROLE_CLOSE;
            iw = 1'b0;
          end else begin
            grp.roles[pos[1:0]]  = utf8ws_pkg::ROLE_WORD;
            grp.wstart[pos[1:0]] = !iw;
            iw = 1'b1;
          end
          pos = pos + 3'd1;
        end
      end
    end

    // terminating nul is reported as whitespace after the flushed bytes
    grp.count = pos[1:0];
    if (ending && in_src_byte == utf8ws_pkg::CH_NUL) begin
      grp.bytes[pos[1:0]]  = utf8ws_pkg::CH_NUL;
      grp.roles[pos[1:0]]  = utf8ws_pkg::ROLE_SPACE;
      grp.wstart[pos[1:0]] = 1'b0;
      grp.count = pos[1:0] + 2'd1;
    end

    in_word_nxt = ending ? 1'b0 : iw;
  end

  assign q_data = grp;
  assign q_push = accept && (grp.count != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      in_word_r  <= 1'b0;
    end else if (accept) begin
      held_cnt_r <= held_cnt_nxt;
      in_word_r  <= in_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

// ===== src/utf8ws_queue.sv =====
module utf8ws_queue #(
  parameter int DEPTH = utf8ws_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  utf8ws_pkg::group_t push_data,
  input  logic               pop,
  output utf8ws_pkg::group_t head,
  output logic               empty,
  output logic               full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utf8ws_pkg::group_t entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == CW'(0));
  assign full  = (cnt_r == CW'(DEPTH));
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_r + PW'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/utf8ws_back.sv =====
module utf8ws_back (
  input  logic               clk,
  input  logic               rst_n,
  input  utf8ws_pkg::group_t head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_role,
  output logic               out_word_start,
  output logic               out_final_result
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic [1:0] role_r;
  logic       wstart_r;
  logic       final_r;
  logic       load;
  logic       last_slot;

  assign load      = (!valid_r || !out_stall) && !empty;
  assign last_slot = (idx_r == head.count - 2'd1);
  assign pop       = load && last_slot;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = last_slot ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= head.bytes[idx_r];
      role_r   <= head.roles[idx_r];
      wstart_r <= head.wstart[idx_r];
      final_r  <= head.last && last_slot;
    end
  end

  assign out_valid        = valid_r;
  assign out_byte         = byte_r;
  assign out_role         = role_r;
  assign out_word_start   = wstart_r;
  assign out_final_result = final_r;

endmodule
